### design/dsrfs_pkg.sv
// Shared types, constants and frame byte table for the switch frame sender.
package dsrfs_pkg;

	localparam int CntW      = 16;
	localparam int ByteW     = 8;
	localparam int FrameLen  = 22;
	localparam int IdxW      = 5;
	localparam int FifoDepth = 2;
	localparam int PtrW      = 1;
	localparam int CountW    = 2;

	localparam logic [CntW-1:0] CntMax = 16'hFFFF;

	// Configuration register indexes
	localparam logic [1:0] RegDebounce = 2'd0;
	localparam logic [1:0] RegRefresh  = 2'd1;
	localparam logic [1:0] RegTarget   = 2'd2;
	localparam logic [1:0] RegActive   = 2'd3;

	// Configuration reset values
	localparam logic [CntW-1:0]  DebounceReset = 16'd50;
	localparam logic [CntW-1:0]  RefreshReset  = 16'd5000;
	localparam logic [ByteW-1:0] TargetReset   = 8'hAC;
	localparam logic             ActiveReset   = 1'b1;

	// Fixed frame bytes
	localparam logic [ByteW-1:0] HdrA      = 8'h4E;
	localparam logic [ByteW-1:0] HdrB      = 8'h57;
	localparam logic [ByteW-1:0] HdrLen    = 8'h14;
	localparam logic [ByteW-1:0] CmdWrite  = 8'h02;
	localparam logic [ByteW-1:0] CmdSub    = 8'h03;
	localparam logic [ByteW-1:0] TailMark  = 8'h68;
	// Sum of the fixed bytes among the first 18
	localparam logic [CntW-1:0]  FixedSum  = 16'h0126;

	localparam logic [IdxW-1:0] IdxLast = 5'd21;

	typedef struct packed {
		logic             on;
		logic [ByteW-1:0] target;
	} req_t;

	function automatic logic [ByteW-1:0] frame_byte(input logic [IdxW-1:0] idx,
			input req_t req);
		logic [CntW-1:0]  sum;
		logic [ByteW-1:0] b;
		sum = FixedSum + {8'd0, req.target} + {15'd0, req.on};
		case (idx)
			5'd0:    b = HdrA;
			5'd1:    b = HdrB;
			5'd3:    b = HdrLen;
			5'd8:    b = CmdWrite;
			5'd9:    b = CmdSub;
			5'd11:   b = req.target;
			5'd12:   b = {7'd0, req.on};
			5'd17:   b = TailMark;
			5'd20:   b = sum[15:8];
			5'd21:   b = sum[7:0];
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

### design/dsrfs_front.sv
// Tick front end: configuration registers, debounce and frame request decision.
module dsrfs_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [dsrfs_pkg::CntW-1:0]    cfg_data,
	input  logic                          tick_valid,
	input  logic                          tick_level,
	input  logic                          space,
	output logic                          tick_ready,
	output logic                          push,
	output dsrfs_pkg::req_t               push_req
);

	logic [dsrfs_pkg::CntW-1:0]  debounce_q;
	logic [dsrfs_pkg::CntW-1:0]  refresh_q;
	logic [dsrfs_pkg::ByteW-1:0] target_q;
	logic                        active_q;

	logic                        raw_seen_q;
	logic                        stable_q;
	logic                        started_q;
	logic [dsrfs_pkg::CntW-1:0]  edge_cnt_q;
	logic [dsrfs_pkg::CntW-1:0]  refresh_cnt_q;

	logic                        accept;
	logic                        raw;
	logic                        send;
	logic                        stable_d;
	logic [dsrfs_pkg::CntW-1:0]  edge_d;
	logic [dsrfs_pkg::CntW-1:0]  refresh_d;

	assign tick_ready = space;
	assign accept     = tick_valid && space;
	assign raw        = (tick_level == active_q);

	always_comb begin
		send      = 1'b0;
		stable_d  = stable_q;
		edge_d    = edge_cnt_q;
		refresh_d = refresh_cnt_q;
		if (!started_q) begin
			send      = 1'b1;
			stable_d  = raw;
			refresh_d = '0;
		end else begin
			edge_d    = (edge_cnt_q == dsrfs_pkg::CntMax) ? edge_cnt_q
				: edge_cnt_q + 16'd1;
			refresh_d = (refresh_cnt_q == dsrfs_pkg::CntMax) ? refresh_cnt_q
				: refresh_cnt_q + 16'd1;
			if (raw != raw_seen_q) begin
				edge_d = '0;
			end
			if (edge_d >= debounce_q && raw != stable_q) begin
				send      = 1'b1;
				stable_d  = raw;
				refresh_d = '0;
			end else if (refresh_d >= refresh_q) begin
				send      = 1'b1;
				refresh_d = '0;
			end
		end
	end

	assign push            = accept && send;
	assign push_req.on     = stable_d;
	assign push_req.target = target_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= dsrfs_pkg::DebounceReset;
			refresh_q  <= dsrfs_pkg::RefreshReset;
			target_q   <= dsrfs_pkg::TargetReset;
			active_q   <= dsrfs_pkg::ActiveReset;
		end else if (cfg_we) begin
			case (cfg_index)
				dsrfs_pkg::RegDebounce: debounce_q <= cfg_data;
				dsrfs_pkg::RegRefresh:  refresh_q  <= cfg_data;
				dsrfs_pkg::RegTarget:   target_q   <= cfg_data[7:0];
				dsrfs_pkg::RegActive:   active_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_seen_q    <= 1'b0;
			stable_q      <= 1'b0;
			started_q     <= 1'b0;
			edge_cnt_q    <= dsrfs_pkg::CntMax;
			refresh_cnt_q <= '0;
		end else if (accept) begin
			started_q     <= 1'b1;
			raw_seen_q    <= raw;
			stable_q      <= stable_d;
			edge_cnt_q    <= edge_d;
			refresh_cnt_q <= refresh_d;
		end
	end

endmodule

### design/dsrfs_fifo.sv
// Short request queue between the tick front end and the frame serializer.
module dsrfs_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dsrfs_pkg::req_t push_req,
	input  logic            pop,
	output logic            space,
	output logic            head_valid,
	output dsrfs_pkg::req_t head_req
);

	dsrfs_pkg::req_t                mem_q [dsrfs_pkg::FifoDepth];
	logic [dsrfs_pkg::PtrW-1:0]     wr_ptr_q;
	logic [dsrfs_pkg::PtrW-1:0]     rd_ptr_q;
	logic [dsrfs_pkg::CountW-1:0]   count_q;
	logic                           do_pop;

	assign space      = (count_q != dsrfs_pkg::CountW'(dsrfs_pkg::FifoDepth));
	assign head_valid = (count_q != '0);
	assign head_req   = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### design/dsrfs_back.sv
// Frame serializer: walks one queued request through its 22 frame bytes.
module dsrfs_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  dsrfs_pkg::req_t              head_req,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [dsrfs_pkg::ByteW-1:0]  out_byte,
	output logic                         out_last,
	output logic                         out_on
);

	logic                        busy_q;
	logic [dsrfs_pkg::IdxW-1:0]  idx_q;
	dsrfs_pkg::req_t             cur_q;
	logic                        valid_q;
	logic [dsrfs_pkg::ByteW-1:0] byte_q;
	logic                        last_q;
	logic                        on_q;
	logic                        load;

	assign load      = !valid_q || out_ready;
	assign pop       = load && !busy_q && head_valid;
	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;
	assign out_on    = on_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else if (load) begin
			if (busy_q) begin
				valid_q <= 1'b1;
				idx_q   <= idx_q + 5'd1;
				if (idx_q == dsrfs_pkg::IdxLast) begin
					busy_q <= 1'b0;
				end
			end else if (head_valid) begin
				valid_q <= 1'b1;
				busy_q  <= 1'b1;
				idx_q   <= 5'd1;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	// Payload: first byte comes straight from the queue head
	always_ff @(posedge clk) begin
		if (load) begin
			if (busy_q) begin
				byte_q <= dsrfs_pkg::frame_byte(idx_q, cur_q);
				last_q <= (idx_q == dsrfs_pkg::IdxLast);
				on_q   <= cur_q.on;
			end else if (head_valid) begin
				cur_q  <= head_req;
				byte_q <= dsrfs_pkg::frame_byte('0, head_req);
				last_q <= 1'b0;
				on_q   <= head_req.on;
			end
		end
	end

endmodule

### design/debounced_switch_register_frame_sender.sv
// Each slave request is one millisecond tick carrying a raw button sample in
// s_tdata bit 0. The sample is debounced against debounce_ticks; the first tick
// after reset, every accepted change and every refresh_ticks ticks without a
// frame each queue one 22-byte register-write frame, sent on the master side
// one byte per cycle while m_tready is high, with tlast on the final checksum
// byte and the debounced state on tuser. A tick is taken whenever the two-entry
// request queue has room; a frame then occupies the serializer for all 22 of
// its bytes, and a queued frame follows the previous one with no gap, so frame
// output sets the sustained rate.
module debounced_switch_register_frame_sender (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] button_level, [7:1] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] frame_byte
	output logic        m_tlast,   // last_of_frame
	output logic        m_tuser    // [0] switch_on
);

	logic            space;
	logic            push;
	dsrfs_pkg::req_t push_req;
	logic            pop;
	logic            head_valid;
	dsrfs_pkg::req_t head_req;

	dsrfs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.tick_valid (s_tvalid),
		.tick_level (s_tdata[0]),
		.space      (space),
		.tick_ready (s_tready),
		.push       (push),
		.push_req   (push_req)
	);

	dsrfs_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_req   (push_req),
		.pop        (pop),
		.space      (space),
		.head_valid (head_valid),
		.head_req   (head_req)
	);

	dsrfs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_req   (head_req),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.out_last   (m_tlast),
		.out_on     (m_tuser)
	);

endmodule
